@@ rtl/core/chg_pkg.sv @@
// Shared types, harmony codes and arithmetic helpers for the color harmony core.
// No dependencies; imported by chg_hsv, chg_rgb and the top level.
package chg_pkg;

  localparam logic [1:0] MODE_TRIAD  = 2'd0;
  localparam logic [1:0] MODE_ANALOG = 2'd1;
  localparam logic [1:0] MODE_TETRAD = 2'd2;

  // Reciprocals: x/510 = ((x+1)*RECIP_510) >> 25 for x < 51257,
  // z/625 = (z*RECIP_625) >> 28 for z < 159376.
  localparam logic [16:0] RECIP_510 = 17'd65793;
  localparam logic [18:0] RECIP_625 = 19'd429497;

  typedef struct packed {
    logic [1:0]  mode;
    logic [23:0] col;
    logic [8:0]  hue;
    logic [6:0]  sat;
    logic [6:0]  val;
    logic [6:0]  lig;
  } hsv_t;

  typedef struct packed {
    logic [23:0] col;
    logic [8:0]  hue;
    logic [8:0]  rot;
    logic [6:0]  sat;
    logic [6:0]  val;
    logic [6:0]  lig;
    logic [1:0]  slot;
    logic        last;
  } slot_t;

  typedef struct packed {
    logic [23:0] color;
    logic [8:0]  hue;
    logic [6:0]  sat;
    logic [6:0]  val;
    logic [6:0]  lig;
    logic [1:0]  slot;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [17:0] rem;
    logic [8:0]  q;
  } div_t;

  // Three restoring division steps, quotient bits top..top-2.
  function automatic div_t div3(div_t a, logic [8:0] den, logic [3:0] top);
    div_t        t;
    logic [17:0] sh;
    logic [3:0]  b;
    t = a;
    for (int j = 0; j < 3; j++) begin
      b  = top - 4'(j);
      sh = 18'(den) << b;
      if (t.rem >= sh) begin
        t.rem  = t.rem - sh;
        t.q[b] = 1'b1;
      end
    end
    return t;
  endfunction

  function automatic logic [2:0] run_len(logic [1:0] mode);
    logic [2:0] n;
    unique case (mode)
      MODE_TRIAD:  n = 3'd3;
      MODE_ANALOG: n = 3'd3;
      MODE_TETRAD: n = 3'd4;
      default:     n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [8:0] rot_of(logic [1:0] mode, logic [1:0] k);
    logic [8:0] r;
    r = 9'd0;
    unique case (mode)
      MODE_TRIAD: begin
        if (k == 2'd1) r = 9'd120;
        else if (k == 2'd2) r = 9'd240;
      end
      MODE_ANALOG: begin
        if (k == 2'd1) r = 9'd30;
        else if (k == 2'd2) r = 9'd330;
      end
      MODE_TETRAD: begin
        if (k == 2'd1) r = 9'd60;
        else if (k == 2'd2) r = 9'd180;
        else if (k == 2'd3) r = 9'd240;
      end
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // floor(ch*255/600000) = floor(((ch*17) >> 6) / 625); this is the shifted product.
  function automatic logic [17:0] scale17(logic [19:0] ch);
    logic [24:0] p;
    p = 25'(ch) * 25'd17;
    return 18'(p >> 6);
  endfunction

endpackage

@@ rtl/core/chg_hsv.sv @@
// RGB to integer HSV and lightness, six register stages with pipelined dividers.
// Depends on chg_pkg.
module chg_hsv (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          i_valid,
  output logic          i_ready,
  input  logic [1:0]    i_action,
  input  logic [23:0]   i_color,
  output logic          o_valid,
  input  logic          o_ready,
  output chg_pkg::hsv_t o_item
);
  import chg_pkg::*;

  localparam logic [1:0] SEL_R = 2'd0;
  localparam logic [1:0] SEL_G = 2'd1;
  localparam logic [1:0] SEL_B = 2'd2;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6    = !v6_r || o_ready;
  assign rdy5    = !v5_r || rdy6;
  assign rdy4    = !v4_r || rdy5;
  assign rdy3    = !v3_r || rdy4;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign i_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; v6_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= i_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  // stage 1: max, min, spread
  logic [7:0] r0, g0, b0, mx_nxt, mn_nxt;
  logic [1:0] sel_nxt;
  logic [1:0]  mode1_r;
  logic [23:0] col1_r;
  logic [7:0]  mx1_r, mn1_r, d1_r;
  logic [1:0]  sel1_r;

  always_comb begin
    r0 = i_color[23:16];
    g0 = i_color[15:8];
    b0 = i_color[7:0];
    mx_nxt = r0;
    if (g0 > mx_nxt) mx_nxt = g0;
    if (b0 > mx_nxt) mx_nxt = b0;
    mn_nxt = r0;
    if (g0 < mn_nxt) mn_nxt = g0;
    if (b0 < mn_nxt) mn_nxt = b0;
    priority if (mx_nxt == r0) sel_nxt = SEL_R;
    else if (mx_nxt == g0)     sel_nxt = SEL_G;
    else                       sel_nxt = SEL_B;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      mode1_r <= i_action;
      col1_r  <= i_color;
      mx1_r   <= mx_nxt;
      mn1_r   <= mn_nxt;
      d1_r    <= mx_nxt - mn_nxt;
      sel1_r  <= sel_nxt;
    end
  end

  // stage 2: dividends and divisors
  logic [17:0] r1, g1, b1, d1x, num_nxt;
  logic [1:0]  mode2_r;
  logic [23:0] col2_r;
  div_t        hd2_r, sd2_r;
  logic [8:0]  hden2_r, sden2_r;
  logic        hz2_r, sz2_r;
  logic [15:0] vx2_r, lx2_r;

  always_comb begin
    r1  = 18'(col1_r[23:16]);
    g1  = 18'(col1_r[15:8]);
    b1  = 18'(col1_r[7:0]);
    d1x = 18'(d1_r);
    unique case (sel1_r)
      SEL_R:   num_nxt = g1 * 18'd60 + d1x * 18'd360 - b1 * 18'd60;
      SEL_G:   num_nxt = b1 * 18'd60 + d1x * 18'd120 - r1 * 18'd60;
      default: num_nxt = r1 * 18'd60 + d1x * 18'd240 - g1 * 18'd60;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      mode2_r   <= mode1_r;
      col2_r    <= col1_r;
      hd2_r.rem <= (num_nxt << 1) + d1x;
      hd2_r.q   <= '0;
      hden2_r   <= {d1_r, 1'b0};
      hz2_r     <= (d1_r == 8'd0);
      sd2_r.rem <= d1x * 18'd200 + 18'(mx1_r);
      sd2_r.q   <= '0;
      sden2_r   <= {mx1_r, 1'b0};
      sz2_r     <= (mx1_r == 8'd0);
      vx2_r     <= 16'(mx1_r) * 16'd200 + 16'd256;
      lx2_r     <= (16'(mx1_r) + 16'(mn1_r)) * 16'd100 + 16'd256;
    end
  end

  // stages 3 to 5: three quotient bits each
  logic [1:0]  mode3_r, mode4_r, mode5_r;
  logic [23:0] col3_r, col4_r, col5_r;
  div_t        hd3_r, sd3_r, hd4_r, sd4_r, hd5_r, sd5_r;
  logic [8:0]  hden3_r, sden3_r, hden4_r, sden4_r;
  logic        hz3_r, sz3_r, hz4_r, sz4_r, hz5_r, sz5_r;
  logic [32:0] vp3_r, lp3_r;
  logic [6:0]  val4_r, lig4_r, val5_r, lig5_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      mode3_r <= mode2_r;
      col3_r  <= col2_r;
      hd3_r   <= div3(hd2_r, hden2_r, 4'd8);
      sd3_r   <= div3(sd2_r, sden2_r, 4'd8);
      hden3_r <= hden2_r;
      sden3_r <= sden2_r;
      hz3_r   <= hz2_r;
      sz3_r   <= sz2_r;
      vp3_r   <= 33'(vx2_r) * 33'(RECIP_510);
      lp3_r   <= 33'(lx2_r) * 33'(RECIP_510);
    end
    if (rdy4) begin
      mode4_r <= mode3_r;
      col4_r  <= col3_r;
      hd4_r   <= div3(hd3_r, hden3_r, 4'd5);
      sd4_r   <= div3(sd3_r, sden3_r, 4'd5);
      hden4_r <= hden3_r;
      sden4_r <= sden3_r;
      hz4_r   <= hz3_r;
      sz4_r   <= sz3_r;
      val4_r  <= vp3_r[31:25];
      lig4_r  <= lp3_r[31:25];
    end
    if (rdy5) begin
      mode5_r <= mode4_r;
      col5_r  <= col4_r;
      hd5_r   <= div3(hd4_r, hden4_r, 4'd2);
      sd5_r   <= div3(sd4_r, sden4_r, 4'd2);
      hz5_r   <= hz4_r;
      sz5_r   <= sz4_r;
      val5_r  <= val4_r;
      lig5_r  <= lig4_r;
    end
  end

  // stage 6: wrap hue, zero the degenerate cases
  hsv_t item_r;
  logic [8:0] hq;

  assign hq = hd5_r.q;

  always_ff @(posedge clk) begin
    if (rdy6) begin
      item_r.mode <= mode5_r;
      item_r.col  <= col5_r;
      if (hz5_r)             item_r.hue <= 9'd0;
      else if (hq >= 9'd360) item_r.hue <= hq - 9'd360;
      else                   item_r.hue <= hq;
      item_r.sat  <= sz5_r ? 7'd0 : sd5_r.q[6:0];
      item_r.val  <= val5_r;
      item_r.lig  <= lig5_r;
    end
  end

  assign o_valid = v6_r;
  assign o_item  = item_r;

endmodule

@@ rtl/core/chg_rgb.sv @@
// Rotated HSV back to truncated RGB, six register stages, one slot per cycle while o_ready allows.
// Depends on chg_pkg.
module chg_rgb (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           i_valid,
  output logic           i_ready,
  input  chg_pkg::slot_t i_slot,
  output logic           o_valid,
  input  logic           o_ready,
  output chg_pkg::res_t  o_res
);
  import chg_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6    = !v6_r || o_ready;
  assign rdy5    = !v5_r || rdy6;
  assign rdy4    = !v4_r || rdy5;
  assign rdy3    = !v3_r || rdy4;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign i_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; v6_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= i_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  // stage 1: rotate hue, s*v
  logic [9:0]  hsum;
  slot_t       s1_r, s2_r, s3_r, s4_r, s5_r;
  logic [8:0]  h1_r, h2_r, h3_r, h4_r, h5_r;
  logic [13:0] sv1_r, sv2_r;

  assign hsum = 10'(i_slot.hue) + 10'(i_slot.rot);

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_r  <= i_slot;
      h1_r  <= (hsum >= 10'd360) ? 9'(hsum - 10'd360) : hsum[8:0];
      sv1_r <= 14'(i_slot.sat) * 14'(i_slot.val);
    end
  end

  // stage 2: sector and offset, chroma and value scaled by 600000
  logic [2:0]  sect_nxt;
  logic [8:0]  base;
  logic [2:0]  sect2_r, sect3_r;
  logic [5:0]  f2_r;
  logic [19:0] c2_r, vm2_r, vm3_r, x3_r, m3_r;

  always_comb begin
    priority if (h1_r < 9'd60) begin sect_nxt = 3'd0; base = 9'd0;   end
    else if (h1_r < 9'd120)    begin sect_nxt = 3'd1; base = 9'd60;  end
    else if (h1_r < 9'd180)    begin sect_nxt = 3'd2; base = 9'd120; end
    else if (h1_r < 9'd240)    begin sect_nxt = 3'd3; base = 9'd180; end
    else if (h1_r < 9'd300)    begin sect_nxt = 3'd4; base = 9'd240; end
    else                       begin sect_nxt = 3'd5; base = 9'd300; end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_r    <= s1_r;
      h2_r    <= h1_r;
      sect2_r <= sect_nxt;
      f2_r    <= 6'(h1_r - base);
      sv2_r   <= sv1_r;
      c2_r    <= 20'(sv1_r) * 20'd60;
      vm2_r   <= 20'(s1_r.val) * 20'd6000;
    end
  end

  // stage 3: second component and offset
  logic [5:0] fm;

  assign fm = sect2_r[0] ? 6'(6'd60 - f2_r) : f2_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_r    <= s2_r;
      h3_r    <= h2_r;
      sect3_r <= sect2_r;
      x3_r    <= 20'(sv2_r) * 20'(fm);
      m3_r    <= vm2_r - c2_r;
      vm3_r   <= vm2_r;
    end
  end

  // stage 4: place channels, prescale
  logic [19:0] hi, mid, lo, cr, cg, cb;
  logic [17:0] zr4_r, zg4_r, zb4_r;

  always_comb begin
    hi  = vm3_r;
    mid = x3_r + m3_r;
    lo  = m3_r;
    unique case (sect3_r)
      3'd0:    begin cr = hi;  cg = mid; cb = lo;  end
      3'd1:    begin cr = mid; cg = hi;  cb = lo;  end
      3'd2:    begin cr = lo;  cg = hi;  cb = mid; end
      3'd3:    begin cr = lo;  cg = mid; cb = hi;  end
      3'd4:    begin cr = mid; cg = lo;  cb = hi;  end
      default: begin cr = hi;  cg = lo;  cb = mid; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_r  <= s3_r;
      h4_r  <= h3_r;
      zr4_r <= scale17(cr);
      zg4_r <= scale17(cg);
      zb4_r <= scale17(cb);
    end
  end

  // stage 5: reciprocal multiply for /625
  logic [36:0] pr5_r, pg5_r, pb5_r;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_r  <= s4_r;
      h5_r  <= h4_r;
      pr5_r <= 37'(zr4_r) * 37'(RECIP_625);
      pg5_r <= 37'(zg4_r) * 37'(RECIP_625);
      pb5_r <= 37'(zb4_r) * 37'(RECIP_625);
    end
  end

  // stage 6: result register; slot zero passes the input color through
  res_t res_r;

  always_ff @(posedge clk) begin
    if (rdy6) begin
      res_r.color <= (s5_r.slot == 2'd0) ? s5_r.col
                                          : {pr5_r[35:28], pg5_r[35:28], pb5_r[35:28]};
      res_r.hue   <= h5_r;
      res_r.sat   <= s5_r.sat;
      res_r.val   <= s5_r.val;
      res_r.lig   <= s5_r.lig;
      res_r.slot  <= s5_r.slot;
      res_r.last  <= s5_r.last;
    end
  end

  assign o_valid = v6_r;
  assign o_res   = res_r;

endmodule

@@ rtl/core/color_harmony_generator_core.sv @@
// Color harmony generator: RGB in, a run of harmony colors with HSV data out.
// Instantiates chg_hsv and chg_rgb; depends on chg_pkg.
//
// Input channel (in_valid / in_stall): one beat carries a harmony mode and a
// 24-bit RGB color. Result channel (out_valid / out_stall): one beat per color
// of the run; slot 0 is the input color, then the rotated hues. Triad and
// analogous runs have three beats, tetrad four, the unused mode one; out_last
// marks the final beat of a run.
// The first beat of a run passes the HSV pipeline, the sequencer register and
// the RGB pipeline. Throughput: one result beat per cycle when not stalled;
// the single result channel admits one item per run, the next item being taken
// as the last slot issues. The 6-stage HSV pipeline takes inputs meanwhile.
// Reset (synchronous, rst_n low) empties every stage; nothing is in flight.
// When out_stall is high, beats pile up in the stages behind the output
// register; once those are full, in_stall rises. No beat is lost or repeated.
module color_harmony_generator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [23:0] in_color_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_color_out,
  output logic [8:0]  out_hue_out,
  output logic [6:0]  out_sat_out,
  output logic [6:0]  out_val_out,
  output logic [6:0]  out_in_lightness,
  output logic [1:0]  out_slot,
  output logic        out_last
);
  import chg_pkg::*;

  logic  hsv_i_ready, hsv_o_valid, hsv_o_ready;
  hsv_t  hsv_item;
  logic  rgb_i_ready;
  slot_t slot_beat;
  res_t  res;

  chg_hsv u_hsv (
    .clk      (clk),
    .rst_n    (rst_n),
    .i_valid  (in_valid),
    .i_ready  (hsv_i_ready),
    .i_action (in_action),
    .i_color  (in_color_in),
    .o_valid  (hsv_o_valid),
    .o_ready  (hsv_o_ready),
    .o_item   (hsv_item)
  );

  assign in_stall = !hsv_i_ready;

  // run sequencer: hold one item, issue its slots one per cycle while the RGB pipeline is ready
  logic       seq_v_r;
  logic [1:0] k_r;
  hsv_t       cur_r;
  logic [2:0] n;
  logic       is_last;

  assign n           = run_len(cur_r.mode);
  assign is_last     = (k_r == 2'(n - 3'd1));
  assign hsv_o_ready = !seq_v_r || (rgb_i_ready && is_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_v_r <= 1'b0;
      k_r     <= 2'd0;
    end else if (hsv_o_ready) begin
      seq_v_r <= hsv_o_valid;
      k_r     <= 2'd0;
    end else if (seq_v_r && rgb_i_ready) begin
      k_r <= k_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (hsv_o_ready) cur_r <= hsv_item;
  end

  always_comb begin
    slot_beat.col  = cur_r.col;
    slot_beat.hue  = cur_r.hue;
    slot_beat.rot  = rot_of(cur_r.mode, k_r);
    slot_beat.sat  = cur_r.sat;
    slot_beat.val  = cur_r.val;
    slot_beat.lig  = cur_r.lig;
    slot_beat.slot = k_r;
    slot_beat.last = is_last;
  end

  chg_rgb u_rgb (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (seq_v_r),
    .i_ready (rgb_i_ready),
    .i_slot  (slot_beat),
    .o_valid (out_valid),
    .o_ready (!out_stall),
    .o_res   (res)
  );

  assign out_color_out    = res.color;
  assign out_hue_out      = res.hue;
  assign out_sat_out      = res.sat;
  assign out_val_out      = res.val;
  assign out_in_lightness = res.lig;
  assign out_slot         = res.slot;
  assign out_last         = res.last;

endmodule
